>>> rtl/gbd_pkg.sv
// gbd_pkg: shared types, codes and constants of the birth-death step block
// used by every module of the block and by the channel interfaces
package gbd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned PAY_W = 16;
  localparam int unsigned INIT_W = 24;
  localparam int unsigned LOG_FRAC_BITS = 24;
  localparam int unsigned LOG_CNT_W = $clog2(LOG_FRAC_BITS);
  localparam int unsigned DIV_W = 48;
  localparam int unsigned DVS_W = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned FRAC_Q_W = 17;
  localparam int unsigned FACC_W = 36;
  localparam int unsigned MUL_W = 33;

  localparam logic [WORD_W-1:0] COUNT_ONE = 32'd256;
  localparam logic [WORD_W-1:0] COUNT_MAX = 32'hFFFFFFFF;
  localparam logic [WORD_W-1:0] LN2_Q32 = 32'd2977044472;
  localparam logic [WORD_W-1:0] DIV10_MAGIC = 32'hCCCCCCCD;
  localparam logic [WORD_W-1:0] RST_C_POP = 32'd179200;
  localparam logic signed [FACC_W-1:0] FACT_ONE = 36'sh001000000;

  typedef enum logic [IDX_W-1:0] {
    REG_DEATH_COEFF = 3'd0,
    REG_PAYOFF_CC   = 3'd1,
    REG_PAYOFF_CD   = 3'd2,
    REG_PAYOFF_DC   = 3'd3,
    REG_PAYOFF_DD   = 3'd4,
    REG_INIT_C      = 3'd5,
    REG_SAMPLE_PER  = 3'd6,
    REG_SAMPLE_TOL  = 3'd7
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    EV_C_DEATH = 3'd0,
    EV_C_BIRTH = 3'd1,
    EV_D_DEATH = 3'd2,
    EV_D_BIRTH = 3'd3,
    EV_NONE    = 3'd4,
    EV_RESTART = 3'd5
  } event_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_FC_GO, S_FC_W, S_FD_GO, S_FD_W,
    S_CB, S_TN1, S_DB, S_TN2, S_PCC, S_PCD, S_FSUM1, S_FC_MUL,
    S_PDC, S_PDD, S_FSUM2, S_FD_MUL, S_A4, S_S3, S_TOT, S_TCHK,
    S_XH, S_XL, S_X, S_KIND, S_LOG_INIT, S_LOG_SQ, S_LOG_NRM,
    S_LOG_NL, S_LOG_MUL, S_TAU_GO, S_TAU_W, S_UPD, S_MARK, S_DIV10,
    S_FIN, S_NOEVT, S_RESTART, S_EMIT
  } state_e;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_FC_GO, OP_FC_W, OP_FD_GO, OP_FD_W,
    OP_MUL_CB, OP_MUL_TN, OP_MUL_DB, OP_MUL_PCC, OP_MUL_PCD, OP_FSUM,
    OP_MUL_FC, OP_MUL_PDC, OP_MUL_PDD, OP_MUL_FD, OP_A4, OP_S3, OP_TOT,
    OP_MUL_XH, OP_MUL_XL, OP_X, OP_KIND, OP_LOG_INIT, OP_LOG_SQ,
    OP_LOG_NRM, OP_LOG_NL, OP_LOG_MUL, OP_TAU_GO, OP_TAU_W, OP_UPD,
    OP_MARK, OP_DIV10, OP_FIN, OP_NOEVT, OP_RESTART, OP_EMIT
  } op_e;

  typedef struct packed {
    logic [WORD_W-1:0] death_coeff;
    logic [PAY_W-1:0]  payoff_cc;
    logic [PAY_W-1:0]  payoff_cd;
    logic [PAY_W-1:0]  payoff_dc;
    logic [PAY_W-1:0]  payoff_dd;
    logic [INIT_W-1:0] initial_c_count;
    logic [WORD_W-1:0] sample_period;
    logic [WORD_W-1:0] sample_tolerance;
  } cfg_t;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd_step;
    logic n_zero;
    logic tot_zero;
    logic div_done;
    logic log_last;
    logic out_free;
  } ctrl_status_t;

endpackage

>>> rtl/gbd_if.sv
// gbd channel interfaces: step items, result items and register writes
// depends on gbd_pkg for widths
interface gbd_step_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [gbd_pkg::WORD_W-1:0]  rand_time;
  logic [gbd_pkg::WORD_W-1:0]  rand_event;
  modport source (output valid, cmd, rand_time, rand_event, input ready);
  modport sink (input valid, cmd, rand_time, rand_event, output ready);
endinterface

interface gbd_result_if;
  logic                        valid;
  logic                        ready;
  logic [gbd_pkg::KIND_W-1:0]  event_kind;
  logic [gbd_pkg::WORD_W-1:0]  sim_time;
  logic [gbd_pkg::WORD_W-1:0]  c_count;
  logic [gbd_pkg::WORD_W-1:0]  d_count;
  logic                        sample_taken;
  modport source (output valid, event_kind, sim_time, c_count, d_count, sample_taken,
                  input ready);
  modport sink (input valid, event_kind, sim_time, c_count, d_count, sample_taken,
                output ready);
endinterface

interface gbd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gbd_pkg::IDX_W-1:0]   reg_index;
  logic [gbd_pkg::WORD_W-1:0]  wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/gbd_cfg_regs.sv
// gbd_cfg_regs: configuration register file written over the register channel
// depends on gbd_pkg
module gbd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  input  logic [gbd_pkg::IDX_W-1:0]  wr_index_i,
  input  logic [gbd_pkg::WORD_W-1:0] wr_data_i,
  output logic                       wr_ready_o,
  output gbd_pkg::cfg_t              cfg_o
);

  gbd_pkg::cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.death_coeff      <= 32'd42950;
      cfg_q.payoff_cc        <= 16'd256;
      cfg_q.payoff_cd        <= 16'd256;
      cfg_q.payoff_dc        <= 16'd256;
      cfg_q.payoff_dd        <= 16'd1024;
      cfg_q.initial_c_count  <= 24'd700;
      cfg_q.sample_period    <= 32'd32768;
      cfg_q.sample_tolerance <= 32'd328;
    end else if (wr_valid_i) begin
      case (gbd_pkg::reg_idx_e'(wr_index_i))
        gbd_pkg::REG_DEATH_COEFF: cfg_q.death_coeff      <= wr_data_i;
        gbd_pkg::REG_PAYOFF_CC:   cfg_q.payoff_cc        <= wr_data_i[15:0];
        gbd_pkg::REG_PAYOFF_CD:   cfg_q.payoff_cd        <= wr_data_i[15:0];
        gbd_pkg::REG_PAYOFF_DC:   cfg_q.payoff_dc        <= wr_data_i[15:0];
        gbd_pkg::REG_PAYOFF_DD:   cfg_q.payoff_dd        <= wr_data_i[15:0];
        gbd_pkg::REG_INIT_C:      cfg_q.initial_c_count  <= wr_data_i[23:0];
        gbd_pkg::REG_SAMPLE_PER:  cfg_q.sample_period    <= wr_data_i;
        gbd_pkg::REG_SAMPLE_TOL:  cfg_q.sample_tolerance <= wr_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/gbd_divider.sv
// gbd_divider: restoring divider, one quotient bit per cycle
// depends on gbd_pkg for widths
module gbd_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gbd_pkg::DIV_W-1:0] dividend_i,
  input  logic [gbd_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [gbd_pkg::DIV_W-1:0] quotient_o
);

  logic                          busy_q, done_q;
  logic [gbd_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [gbd_pkg::DVS_W-1:0]     rem_q, dvs_q;
  logic [gbd_pkg::DIV_W-1:0]     quo_q;
  logic [gbd_pkg::DVS_W:0]       rem_sh, rem_sub;
  logic                          fits;

  assign rem_sh     = {rem_q, quo_q[gbd_pkg::DIV_W-1]};
  assign rem_sub    = rem_sh - {1'b0, dvs_q};
  assign fits       = rem_sh >= {1'b0, dvs_q};
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == gbd_pkg::DIV_CNT_W'(gbd_pkg::DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[gbd_pkg::DVS_W-1:0] : rem_sh[gbd_pkg::DVS_W-1:0];
      quo_q <= {quo_q[gbd_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

>>> rtl/gbd_datapath.sv
// gbd_datapath: population state, rate arithmetic, logarithm, shared multiplier
// depends on gbd_pkg and gbd_divider; driven by gbd_controller commands
module gbd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbd_pkg::cfg_t               cfg_i,
  input  gbd_pkg::ctrl_cmd_t          cmd_i,
  output gbd_pkg::ctrl_status_t       status_o,
  input  logic                        in_cmd_i,
  input  logic [gbd_pkg::WORD_W-1:0]  in_rand_time_i,
  input  logic [gbd_pkg::WORD_W-1:0]  in_rand_event_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gbd_pkg::KIND_W-1:0]  out_event_kind_o,
  output logic [gbd_pkg::WORD_W-1:0]  out_sim_time_o,
  output logic [gbd_pkg::WORD_W-1:0]  out_c_count_o,
  output logic [gbd_pkg::WORD_W-1:0]  out_d_count_o,
  output logic                        out_sample_taken_o
);

  localparam int unsigned W = gbd_pkg::WORD_W;
  localparam int unsigned M = gbd_pkg::MUL_W;

  // state of the simulation
  logic [W-1:0] c_pop_q, d_pop_q, elapsed_q, mark_idx_q;
  logic         out_valid_q;

  // work registers
  logic                                cmd_q;
  logic [W-1:0]                        rt_q, re_q, n_q;
  logic [gbd_pkg::FRAC_Q_W-1:0]        fc_q, fd_q;
  logic [2*W-1:0]                      prod_q, a1_q, a2_q, a3_q, a4_q;
  logic [2*W-1:0]                      s2_q, s3_q, total_q, xacc_q, x_q;
  logic signed [gbd_pkg::FACC_W-1:0]   facc_q;
  logic [W-1:0]                        m_q;
  logic [gbd_pkg::LOG_FRAC_BITS-1:0]   frac_q;
  logic [gbd_pkg::LOG_CNT_W-1:0]       log_cnt_q;
  logic [4:0]                          lead_q;
  logic [29:0]                         nl_q;
  logic [gbd_pkg::DIV_W-1:0]           tau_q;
  gbd_pkg::event_e                     kind_q, res_kind_q, out_kind_q;
  logic                                hit_q, res_hit_q, out_hit_q;
  logic [W-1:0]                        res_time_q, res_c_q, res_d_q;
  logic [W-1:0]                        out_time_q, out_c_q, out_d_q;

  // combinational helpers
  logic signed [M-1:0]         mul_a, mul_b;
  logic signed [2*M-1:0]       mul_p;
  logic                        mul_en;
  logic                        div_start, div_done;
  logic [gbd_pkg::DIV_W-1:0]   div_dvd, div_q;
  logic [gbd_pkg::DVS_W-1:0]   div_dvs;
  logic [W:0]                  n_sum;
  logic [W-1:0]                n_sat, rt1, m_init, c_inc, c_dec, d_inc, d_dec;
  logic [4:0]                  lead;
  logic [W:0]                  m2;
  logic [26:0]                 f16;
  logic [gbd_pkg::DIV_W:0]     el_sum;
  logic [W-1:0]                el_sat;
  logic [2*W-1:0]              el64, diff;
  logic                        out_free;

  gbd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign n_sum  = {1'b0, c_pop_q} + {1'b0, d_pop_q};
  assign n_sat  = n_sum[W] ? gbd_pkg::COUNT_MAX : n_sum[W-1:0];
  assign rt1    = (rt_q == '0) ? W'(1) : rt_q;
  assign m_init = rt1 << (5'd31 - lead);
  assign m2     = prod_q[2*W-1:W-1];
  assign f16    = facc_q[gbd_pkg::FACC_W-1] ? '0 : facc_q[34:8];
  assign c_inc  = (c_pop_q > gbd_pkg::COUNT_MAX - gbd_pkg::COUNT_ONE) ?
                  gbd_pkg::COUNT_MAX : c_pop_q + gbd_pkg::COUNT_ONE;
  assign c_dec  = (c_pop_q < gbd_pkg::COUNT_ONE) ? '0 : c_pop_q - gbd_pkg::COUNT_ONE;
  assign d_inc  = (d_pop_q > gbd_pkg::COUNT_MAX - gbd_pkg::COUNT_ONE) ?
                  gbd_pkg::COUNT_MAX : d_pop_q + gbd_pkg::COUNT_ONE;
  assign d_dec  = (d_pop_q < gbd_pkg::COUNT_ONE) ? '0 : d_pop_q - gbd_pkg::COUNT_ONE;
  assign el_sum = {17'b0, elapsed_q} + {1'b0, tau_q};
  assign el_sat = (el_sum[gbd_pkg::DIV_W:W] != '0) ? gbd_pkg::COUNT_MAX : el_sum[W-1:0];
  assign el64   = {{W{1'b0}}, elapsed_q};
  assign diff   = (el64 >= prod_q) ? el64 - prod_q : prod_q - el64;
  assign mul_p  = mul_a * mul_b;
  assign out_free = !out_valid_q || out_ready_i;

  // leading one of the time fraction
  always_comb begin
    lead = '0;
    for (int i = 0; i < W; i++) begin
      if (rt1[i]) lead = 5'(i);
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      gbd_pkg::OP_MUL_CB: begin
        mul_a = {1'b0, c_pop_q};
        mul_b = {1'b0, cfg_i.death_coeff};
      end
      gbd_pkg::OP_MUL_TN: begin
        mul_a = {1'b0, prod_q[2*W-1:W]};
        mul_b = {1'b0, n_q};
      end
      gbd_pkg::OP_MUL_DB: begin
        mul_a = {1'b0, d_pop_q};
        mul_b = {1'b0, cfg_i.death_coeff};
      end
      gbd_pkg::OP_MUL_PCC: begin
        mul_a = {{17{cfg_i.payoff_cc[15]}}, cfg_i.payoff_cc};
        mul_b = {16'b0, fc_q};
      end
      gbd_pkg::OP_MUL_PCD: begin
        mul_a = {{17{cfg_i.payoff_cd[15]}}, cfg_i.payoff_cd};
        mul_b = {16'b0, fd_q};
      end
      gbd_pkg::OP_MUL_FC: begin
        mul_a = {6'b0, f16};
        mul_b = {1'b0, c_pop_q};
      end
      gbd_pkg::OP_MUL_PDC: begin
        mul_a = {{17{cfg_i.payoff_dc[15]}}, cfg_i.payoff_dc};
        mul_b = {16'b0, fc_q};
      end
      gbd_pkg::OP_MUL_PDD: begin
        mul_a = {{17{cfg_i.payoff_dd[15]}}, cfg_i.payoff_dd};
        mul_b = {16'b0, fd_q};
      end
      gbd_pkg::OP_MUL_FD: begin
        mul_a = {6'b0, f16};
        mul_b = {1'b0, d_pop_q};
      end
      gbd_pkg::OP_MUL_XH: begin
        mul_a = {1'b0, re_q};
        mul_b = {1'b0, total_q[2*W-1:W]};
      end
      gbd_pkg::OP_MUL_XL: begin
        mul_a = {1'b0, re_q};
        mul_b = {1'b0, total_q[W-1:0]};
      end
      gbd_pkg::OP_LOG_SQ: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      gbd_pkg::OP_LOG_MUL: begin
        mul_a = {3'b0, nl_q};
        mul_b = {1'b0, gbd_pkg::LN2_Q32};
      end
      gbd_pkg::OP_MARK: begin
        mul_a = {1'b0, mark_idx_q};
        mul_b = {1'b0, cfg_i.sample_period};
      end
      gbd_pkg::OP_DIV10: begin
        mul_a = {1'b0, c_pop_q};
        mul_b = {1'b0, gbd_pkg::DIV10_MAGIC};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd_i.op)
      gbd_pkg::OP_FC_GO: begin
        div_start = 1'b1;
        div_dvd   = {c_pop_q, 16'b0};
        div_dvs   = {{W{1'b0}}, n_q};
      end
      gbd_pkg::OP_FD_GO: begin
        div_start = 1'b1;
        div_dvd   = {d_pop_q, 16'b0};
        div_dvs   = {{W{1'b0}}, n_q};
      end
      gbd_pkg::OP_TAU_GO: begin
        div_start = 1'b1;
        div_dvd   = {16'b0, prod_q[2*W-1:W]};
        div_dvs   = total_q;
      end
      default: ;
    endcase
  end

  // simulation state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_pop_q     <= gbd_pkg::RST_C_POP;
      d_pop_q     <= '0;
      elapsed_q   <= '0;
      mark_idx_q  <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == gbd_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        gbd_pkg::OP_RESTART: begin
          c_pop_q    <= {cfg_i.initial_c_count, 8'b0};
          d_pop_q    <= '0;
          elapsed_q  <= '0;
          mark_idx_q <= W'(1);
        end
        gbd_pkg::OP_UPD: begin
          elapsed_q <= el_sat;
          case (kind_q)
            gbd_pkg::EV_C_DEATH: c_pop_q <= c_dec;
            gbd_pkg::EV_C_BIRTH: c_pop_q <= c_inc;
            gbd_pkg::EV_D_DEATH: d_pop_q <= d_dec;
            gbd_pkg::EV_D_BIRTH: d_pop_q <= d_inc;
            default: ;
          endcase
        end
        gbd_pkg::OP_FIN: begin
          if (hit_q) begin
            c_pop_q    <= {3'b0, prod_q[2*W-1:35]};
            mark_idx_q <= mark_idx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_p[2*W-1:0];
    case (cmd_i.op)
      gbd_pkg::OP_LOAD: begin
        cmd_q <= in_cmd_i;
        rt_q  <= in_rand_time_i;
        re_q  <= in_rand_event_i;
        n_q   <= n_sat;
      end
      gbd_pkg::OP_FC_W: if (div_done) fc_q <= div_q[gbd_pkg::FRAC_Q_W-1:0];
      gbd_pkg::OP_FD_W: if (div_done) fd_q <= div_q[gbd_pkg::FRAC_Q_W-1:0];
      gbd_pkg::OP_MUL_DB:  a1_q <= {8'b0, prod_q[2*W-1:8]};
      gbd_pkg::OP_MUL_PCC: a3_q <= {8'b0, prod_q[2*W-1:8]};
      gbd_pkg::OP_MUL_PCD, gbd_pkg::OP_MUL_PDD:
        facc_q <= gbd_pkg::FACT_ONE + $signed(prod_q[gbd_pkg::FACC_W-1:0]);
      gbd_pkg::OP_FSUM: facc_q <= facc_q + $signed(prod_q[gbd_pkg::FACC_W-1:0]);
      gbd_pkg::OP_MUL_PDC: a2_q <= {16'b0, prod_q[2*W-1:16]};
      gbd_pkg::OP_A4: begin
        a4_q <= {16'b0, prod_q[2*W-1:16]};
        s2_q <= a1_q + a2_q;
      end
      gbd_pkg::OP_S3:  s3_q <= s2_q + a3_q;
      gbd_pkg::OP_TOT: total_q <= s3_q + a4_q;
      gbd_pkg::OP_MUL_XL: xacc_q <= prod_q;
      gbd_pkg::OP_X: x_q <= xacc_q + {{W{1'b0}}, prod_q[2*W-1:W]};
      gbd_pkg::OP_KIND: begin
        if (x_q < a1_q)      kind_q <= gbd_pkg::EV_C_DEATH;
        else if (x_q < s2_q) kind_q <= gbd_pkg::EV_C_BIRTH;
        else if (x_q < s3_q) kind_q <= gbd_pkg::EV_D_DEATH;
        else                 kind_q <= gbd_pkg::EV_D_BIRTH;
      end
      gbd_pkg::OP_LOG_INIT: begin
        lead_q    <= lead;
        m_q       <= m_init;
        frac_q    <= '0;
        log_cnt_q <= '0;
      end
      gbd_pkg::OP_LOG_NRM: begin
        log_cnt_q <= log_cnt_q + 1'b1;
        if (m2[W]) begin
          m_q    <= m2[W:1];
          frac_q <= {frac_q[gbd_pkg::LOG_FRAC_BITS-2:0], 1'b1};
        end else begin
          m_q    <= m2[W-1:0];
          frac_q <= {frac_q[gbd_pkg::LOG_FRAC_BITS-2:0], 1'b0};
        end
      end
      gbd_pkg::OP_LOG_NL:
        nl_q <= {(6'd32 - {1'b0, lead_q}), 24'b0} - {6'b0, frac_q};
      gbd_pkg::OP_TAU_W: if (div_done) tau_q <= div_q;
      gbd_pkg::OP_DIV10: hit_q <= diff < {{W{1'b0}}, cfg_i.sample_tolerance};
      gbd_pkg::OP_FIN: begin
        res_kind_q <= kind_q;
        res_time_q <= elapsed_q;
        res_c_q    <= c_pop_q;
        res_d_q    <= d_pop_q;
        res_hit_q  <= hit_q;
      end
      gbd_pkg::OP_NOEVT: begin
        res_kind_q <= gbd_pkg::EV_NONE;
        res_time_q <= elapsed_q;
        res_c_q    <= c_pop_q;
        res_d_q    <= d_pop_q;
        res_hit_q  <= 1'b0;
      end
      gbd_pkg::OP_RESTART: begin
        res_kind_q <= gbd_pkg::EV_RESTART;
        res_time_q <= '0;
        res_c_q    <= {cfg_i.initial_c_count, 8'b0};
        res_d_q    <= '0;
        res_hit_q  <= 1'b0;
      end
      gbd_pkg::OP_EMIT: begin
        out_kind_q <= res_kind_q;
        out_time_q <= res_time_q;
        out_c_q    <= res_c_q;
        out_d_q    <= res_d_q;
        out_hit_q  <= res_hit_q;
      end
      default: ;
    endcase
  end

  assign status_o.cmd_step = cmd_q;
  assign status_o.n_zero   = (n_q == '0);
  assign status_o.tot_zero = (total_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.log_last = (log_cnt_q == gbd_pkg::LOG_CNT_W'(gbd_pkg::LOG_FRAC_BITS - 1));
  assign status_o.out_free = out_free;

  assign out_valid_o        = out_valid_q;
  assign out_event_kind_o   = out_kind_q;
  assign out_sim_time_o     = out_time_q;
  assign out_c_count_o      = out_c_q;
  assign out_d_count_o      = out_d_q;
  assign out_sample_taken_o = out_hit_q;

endmodule

>>> rtl/gbd_controller.sv
// gbd_controller: sequencer that steps the datapath through one item
// depends on gbd_pkg for state, command and status types
module gbd_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gbd_pkg::ctrl_status_t status_i,
  output gbd_pkg::ctrl_cmd_t    cmd_o
);

  gbd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbd_pkg::S_IDLE:     if (in_valid_i) state_d = gbd_pkg::S_DISPATCH;
      gbd_pkg::S_DISPATCH: begin
        if (!status_i.cmd_step)   state_d = gbd_pkg::S_RESTART;
        else if (status_i.n_zero) state_d = gbd_pkg::S_NOEVT;
        else                      state_d = gbd_pkg::S_FC_GO;
      end
      gbd_pkg::S_FC_GO:    state_d = gbd_pkg::S_FC_W;
      gbd_pkg::S_FC_W:     if (status_i.div_done) state_d = gbd_pkg::S_FD_GO;
      gbd_pkg::S_FD_GO:    state_d = gbd_pkg::S_FD_W;
      gbd_pkg::S_FD_W:     if (status_i.div_done) state_d = gbd_pkg::S_CB;
      gbd_pkg::S_CB:       state_d = gbd_pkg::S_TN1;
      gbd_pkg::S_TN1:      state_d = gbd_pkg::S_DB;
      gbd_pkg::S_DB:       state_d = gbd_pkg::S_TN2;
      gbd_pkg::S_TN2:      state_d = gbd_pkg::S_PCC;
      gbd_pkg::S_PCC:      state_d = gbd_pkg::S_PCD;
      gbd_pkg::S_PCD:      state_d = gbd_pkg::S_FSUM1;
      gbd_pkg::S_FSUM1:    state_d = gbd_pkg::S_FC_MUL;
      gbd_pkg::S_FC_MUL:   state_d = gbd_pkg::S_PDC;
      gbd_pkg::S_PDC:      state_d = gbd_pkg::S_PDD;
      gbd_pkg::S_PDD:      state_d = gbd_pkg::S_FSUM2;
      gbd_pkg::S_FSUM2:    state_d = gbd_pkg::S_FD_MUL;
      gbd_pkg::S_FD_MUL:   state_d = gbd_pkg::S_A4;
      gbd_pkg::S_A4:       state_d = gbd_pkg::S_S3;
      gbd_pkg::S_S3:       state_d = gbd_pkg::S_TOT;
      gbd_pkg::S_TOT:      state_d = gbd_pkg::S_TCHK;
      gbd_pkg::S_TCHK:     state_d = status_i.tot_zero ? gbd_pkg::S_NOEVT : gbd_pkg::S_XH;
      gbd_pkg::S_XH:       state_d = gbd_pkg::S_XL;
      gbd_pkg::S_XL:       state_d = gbd_pkg::S_X;
      gbd_pkg::S_X:        state_d = gbd_pkg::S_KIND;
      gbd_pkg::S_KIND:     state_d = gbd_pkg::S_LOG_INIT;
      gbd_pkg::S_LOG_INIT: state_d = gbd_pkg::S_LOG_SQ;
      gbd_pkg::S_LOG_SQ:   state_d = gbd_pkg::S_LOG_NRM;
      gbd_pkg::S_LOG_NRM:
        state_d = status_i.log_last ? gbd_pkg::S_LOG_NL : gbd_pkg::S_LOG_SQ;
      gbd_pkg::S_LOG_NL:   state_d = gbd_pkg::S_LOG_MUL;
      gbd_pkg::S_LOG_MUL:  state_d = gbd_pkg::S_TAU_GO;
      gbd_pkg::S_TAU_GO:   state_d = gbd_pkg::S_TAU_W;
      gbd_pkg::S_TAU_W:    if (status_i.div_done) state_d = gbd_pkg::S_UPD;
      gbd_pkg::S_UPD:      state_d = gbd_pkg::S_MARK;
      gbd_pkg::S_MARK:     state_d = gbd_pkg::S_DIV10;
      gbd_pkg::S_DIV10:    state_d = gbd_pkg::S_FIN;
      gbd_pkg::S_FIN:      state_d = gbd_pkg::S_EMIT;
      gbd_pkg::S_NOEVT:    state_d = gbd_pkg::S_EMIT;
      gbd_pkg::S_RESTART:  state_d = gbd_pkg::S_EMIT;
      gbd_pkg::S_EMIT:     if (status_i.out_free) state_d = gbd_pkg::S_IDLE;
      default:             state_d = gbd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = gbd_pkg::OP_NOP;
    case (state_q)
      gbd_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = gbd_pkg::OP_LOAD;
      end
      gbd_pkg::S_FC_GO:    cmd_o.op = gbd_pkg::OP_FC_GO;
      gbd_pkg::S_FC_W:     cmd_o.op = gbd_pkg::OP_FC_W;
      gbd_pkg::S_FD_GO:    cmd_o.op = gbd_pkg::OP_FD_GO;
      gbd_pkg::S_FD_W:     cmd_o.op = gbd_pkg::OP_FD_W;
      gbd_pkg::S_CB:       cmd_o.op = gbd_pkg::OP_MUL_CB;
      gbd_pkg::S_TN1:      cmd_o.op = gbd_pkg::OP_MUL_TN;
      gbd_pkg::S_DB:       cmd_o.op = gbd_pkg::OP_MUL_DB;
      gbd_pkg::S_TN2:      cmd_o.op = gbd_pkg::OP_MUL_TN;
      gbd_pkg::S_PCC:      cmd_o.op = gbd_pkg::OP_MUL_PCC;
      gbd_pkg::S_PCD:      cmd_o.op = gbd_pkg::OP_MUL_PCD;
      gbd_pkg::S_FSUM1:    cmd_o.op = gbd_pkg::OP_FSUM;
      gbd_pkg::S_FC_MUL:   cmd_o.op = gbd_pkg::OP_MUL_FC;
      gbd_pkg::S_PDC:      cmd_o.op = gbd_pkg::OP_MUL_PDC;
      gbd_pkg::S_PDD:      cmd_o.op = gbd_pkg::OP_MUL_PDD;
      gbd_pkg::S_FSUM2:    cmd_o.op = gbd_pkg::OP_FSUM;
      gbd_pkg::S_FD_MUL:   cmd_o.op = gbd_pkg::OP_MUL_FD;
      gbd_pkg::S_A4:       cmd_o.op = gbd_pkg::OP_A4;
      gbd_pkg::S_S3:       cmd_o.op = gbd_pkg::OP_S3;
      gbd_pkg::S_TOT:      cmd_o.op = gbd_pkg::OP_TOT;
      gbd_pkg::S_XH:       cmd_o.op = gbd_pkg::OP_MUL_XH;
      gbd_pkg::S_XL:       cmd_o.op = gbd_pkg::OP_MUL_XL;
      gbd_pkg::S_X:        cmd_o.op = gbd_pkg::OP_X;
      gbd_pkg::S_KIND:     cmd_o.op = gbd_pkg::OP_KIND;
      gbd_pkg::S_LOG_INIT: cmd_o.op = gbd_pkg::OP_LOG_INIT;
      gbd_pkg::S_LOG_SQ:   cmd_o.op = gbd_pkg::OP_LOG_SQ;
      gbd_pkg::S_LOG_NRM:  cmd_o.op = gbd_pkg::OP_LOG_NRM;
      gbd_pkg::S_LOG_NL:   cmd_o.op = gbd_pkg::OP_LOG_NL;
      gbd_pkg::S_LOG_MUL:  cmd_o.op = gbd_pkg::OP_LOG_MUL;
      gbd_pkg::S_TAU_GO:   cmd_o.op = gbd_pkg::OP_TAU_GO;
      gbd_pkg::S_TAU_W:    cmd_o.op = gbd_pkg::OP_TAU_W;
      gbd_pkg::S_UPD:      cmd_o.op = gbd_pkg::OP_UPD;
      gbd_pkg::S_MARK:     cmd_o.op = gbd_pkg::OP_MARK;
      gbd_pkg::S_DIV10:    cmd_o.op = gbd_pkg::OP_DIV10;
      gbd_pkg::S_FIN:      cmd_o.op = gbd_pkg::OP_FIN;
      gbd_pkg::S_NOEVT:    cmd_o.op = gbd_pkg::OP_NOEVT;
      gbd_pkg::S_RESTART:  cmd_o.op = gbd_pkg::OP_RESTART;
      gbd_pkg::S_EMIT:     if (status_i.out_free) cmd_o.op = gbd_pkg::OP_EMIT;
      default: ;
    endcase
  end

endmodule

>>> rtl/gillespie_birth_death_step.sv
// gillespie_birth_death_step: top level of one birth-death simulation replica
// depends on gbd_pkg, gbd_if, gbd_cfg_regs, gbd_controller, gbd_datapath
//
//   channel   dir  handshake     payload
//   item_i    in   valid/ready   cmd, rand_time, rand_event
//   result_o  out  valid/ready   event_kind, sim_time, c_count, d_count, sample_taken
//   cfg_i     in   valid/ready   reg_index, wdata (ready always high)
//
// a full step item runs three divisions on the shared divider and a squaring loop
// on the shared multiplier that forms the 24 fraction bits of the logarithm
// a restart item or a step with zero population skips both on its way to emit
// one item is in work at a time; item_i is ready whenever the sequencer is idle
// a result waits in the output register while the next item is taken
// reset restores config, state, initial population, not work regs; no clearing pass
module gillespie_birth_death_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  gbd_cfg_if.sink      cfg_i,
  gbd_step_if.sink     item_i,
  gbd_result_if.source result_o
);

  gbd_pkg::cfg_t         cfg;
  gbd_pkg::ctrl_cmd_t    ctrl_cmd;
  gbd_pkg::ctrl_status_t ctrl_status;

  gbd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .wr_ready_o (cfg_i.ready),
    .cfg_o      (cfg)
  );

  gbd_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .status_i   (ctrl_status),
    .cmd_o      (ctrl_cmd)
  );

  gbd_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (ctrl_cmd),
    .status_o           (ctrl_status),
    .in_cmd_i           (item_i.cmd),
    .in_rand_time_i     (item_i.rand_time),
    .in_rand_event_i    (item_i.rand_event),
    .out_valid_o        (result_o.valid),
    .out_ready_i        (result_o.ready),
    .out_event_kind_o   (result_o.event_kind),
    .out_sim_time_o     (result_o.sim_time),
    .out_c_count_o      (result_o.c_count),
    .out_d_count_o      (result_o.d_count),
    .out_sample_taken_o (result_o.sample_taken)
  );

endmodule
